### hdl/assert_macros.svh
// Assertion helpers shared by the collision resolver RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clk edge outside reset.
`define BPC_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("bpc assertion failed");

// Same check with a caller supplied message.
`define BPC_ASSERT_MSG(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

`endif

### hdl/bpc_pkg.sv
package bpc_pkg;

    // Pipeline depths
    localparam int SQRT_STEPS = 33;
    localparam int DIV_STEPS  = 31;
    localparam int DIV_LANES  = 3;
    localparam int RES_STAGES = 13;

    // Divider lanes
    localparam int LANE_X = 0;
    localparam int LANE_Y = 1;
    localparam int LANE_F = 2;

    // Outcome codes
    localparam logic [1:0] OUT_NONE  = 2'd0;
    localparam logic [1:0] OUT_HIT   = 2'd1;
    localparam logic [1:0] OUT_NUDGE = 2'd2;

    // Fixed-point constants
    localparam logic signed [39:0] NUDGE_RAW     = 40'sd6554;
    localparam logic [32:0]        NEAR_ZERO_RAW = 33'd7;
    localparam logic [16:0]        REST_RESET    = 17'd58982;
    localparam logic [17:0]        REST_ONE      = 18'd65536;
    localparam logic [30:0]        F_ONE         = 31'h40000000;
    localparam logic [30:0]        F_HALF        = 31'h20000000;
    localparam logic signed [40:0] U_LIMIT       = 41'sd8589934591;

    typedef struct packed {
        logic signed [31:0] a_x;
        logic signed [31:0] a_y;
        logic signed [31:0] a_vx;
        logic signed [31:0] a_vy;
        logic [30:0]        a_radius;
        logic [30:0]        a_mass;
        logic signed [31:0] b_x;
        logic signed [31:0] b_y;
        logic signed [31:0] b_vx;
        logic signed [31:0] b_vy;
        logic [30:0]        b_radius;
        logic [30:0]        b_mass;
    } pair_t;

    typedef struct packed {
        pair_t              p;
        logic signed [32:0] dx;
        logic signed [32:0] dy;
        logic [31:0]        rs;
        logic [31:0]        msum;
    } carry_t;

    typedef struct packed {
        logic signed [31:0] ax;
        logic signed [31:0] ay;
        logic signed [31:0] avx;
        logic signed [31:0] avy;
        logic signed [31:0] bx;
        logic signed [31:0] by;
        logic signed [31:0] bvx;
        logic signed [31:0] bvy;
        logic [1:0]         outcome;
    } result_t;

    typedef struct packed {
        carry_t             c;
        logic [32:0]        d;
        logic [1:0]         cls;
        logic signed [31:0] nx;
        logic signed [31:0] ny;
        logic [30:0]        f2;
        logic signed [33:0] ov;
        logic signed [63:0] pn1a;
        logic signed [63:0] pn1b;
        logic signed [63:0] pn2a;
        logic signed [63:0] pn2b;
        logic signed [63:0] pt1a;
        logic signed [63:0] pt1b;
        logic signed [63:0] pt2a;
        logic signed [63:0] pt2b;
        logic signed [65:0] pox;
        logic signed [65:0] poy;
        logic signed [64:0] sn1;
        logic signed [64:0] sn2;
        logic signed [64:0] st1;
        logic signed [64:0] st2;
        logic signed [33:0] v1n;
        logic signed [33:0] v2n;
        logic signed [33:0] v1t;
        logic signed [33:0] v2t;
        logic signed [33:0] px;
        logic signed [33:0] py;
        logic signed [34:0] dv;
        logic [30:0]        f1;
        logic signed [66:0] pk1;
        logic signed [66:0] pk2;
        logic signed [36:0] t1;
        logic signed [36:0] t2;
        logic signed [55:0] pe1;
        logic signed [55:0] pe2;
        logic signed [39:0] k1;
        logic signed [39:0] k2;
        logic signed [34:0] u1;
        logic signed [34:0] u2;
        logic signed [66:0] qa1;
        logic signed [66:0] qb1;
        logic signed [66:0] qa2;
        logic signed [66:0] qb2;
        logic signed [65:0] qc1;
        logic signed [65:0] qd1;
        logic signed [65:0] qc2;
        logic signed [65:0] qd2;
        logic signed [36:0] ra1;
        logic signed [36:0] rb1;
        logic signed [36:0] rc1;
        logic signed [36:0] rd1;
        logic signed [36:0] ra2;
        logic signed [36:0] rb2;
        logic signed [36:0] rc2;
        logic signed [36:0] rd2;
        result_t            r;
    } res_t;

    // Shift right by s with round half away from zero
    function automatic logic signed [71:0] rnd_sh(input logic signed [71:0] p,
                                                  input int unsigned s);
        logic signed [71:0] h;
        h = 72'sd1 <<< (s - 1);
        if (p < 0) h = h - 72'sd1;
        return (p + h) >>> s;
    endfunction

    // Saturate to 32 bit signed
    function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
        logic signed [31:0] o;
        if (v > 40'sd2147483647) o = 32'sh7FFFFFFF;
        else if (v < -40'sd2147483648) o = 32'sh80000000;
        else o = v[31:0];
        return o;
    endfunction

endpackage

### hdl/bpc_dist.sv
module bpc_dist
    import bpc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        adv,
    input  logic        in_vld,
    input  pair_t       in_pair,
    output logic        out_vld,
    output carry_t      out_car,
    output logic [32:0] out_d
);

    logic        f1_vld_reg, f2_vld_reg;
    carry_t      f1_car_reg, f2_car_reg;
    logic [64:0] sqx_reg, sqy_reg;

    logic        vld_reg  [0:SQRT_STEPS];
    carry_t      car_reg  [0:SQRT_STEPS];
    logic [35:0] rem_reg  [0:SQRT_STEPS];
    logic [32:0] root_reg [0:SQRT_STEPS];
    logic [65:0] xs_reg   [0:SQRT_STEPS];

    logic [35:0] rem_next  [1:SQRT_STEPS];
    logic [32:0] root_next [1:SQRT_STEPS];
    logic [65:0] xs_next   [1:SQRT_STEPS];

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_vld_reg <= 1'b0;
            f2_vld_reg <= 1'b0;
            for (int k = 0; k <= SQRT_STEPS; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else if (adv)
        begin
            f1_vld_reg <= in_vld;
            f2_vld_reg <= f1_vld_reg;
            vld_reg[0] <= f2_vld_reg;
            for (int k = 1; k <= SQRT_STEPS; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    // Differences, squares and their sum
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f1_car_reg.p    <= in_pair;
            f1_car_reg.dx   <= 33'(in_pair.a_x) - 33'(in_pair.b_x);
            f1_car_reg.dy   <= 33'(in_pair.a_y) - 33'(in_pair.b_y);
            f1_car_reg.rs   <= {1'b0, in_pair.a_radius} + {1'b0, in_pair.b_radius};
            f1_car_reg.msum <= {1'b0, in_pair.a_mass} + {1'b0, in_pair.b_mass};
            f2_car_reg      <= f1_car_reg;
            sqx_reg         <= f1_car_reg.dx * f1_car_reg.dx;
            sqy_reg         <= f1_car_reg.dy * f1_car_reg.dy;
            car_reg[0]      <= f2_car_reg;
            rem_reg[0]      <= '0;
            root_reg[0]     <= '0;
            xs_reg[0]       <= {1'b0, sqx_reg} + {1'b0, sqy_reg};
        end
    end

    // One root bit per stage
    always_comb
    begin
        logic [35:0] r4;
        logic [35:0] trial;
        for (int k = 1; k <= SQRT_STEPS; k++)
        begin
            r4    = {rem_reg[k-1][33:0], xs_reg[k-1][65:64]};
            trial = {1'b0, root_reg[k-1], 2'b01};
            if (r4 >= trial)
            begin
                rem_next[k]  = r4 - trial;
                root_next[k] = {root_reg[k-1][31:0], 1'b1};
            end
            else
            begin
                rem_next[k]  = r4;
                root_next[k] = {root_reg[k-1][31:0], 1'b0};
            end
            xs_next[k] = {xs_reg[k-1][63:0], 2'b00};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 1; k <= SQRT_STEPS; k++)
            begin
                car_reg[k]  <= car_reg[k-1];
                rem_reg[k]  <= rem_next[k];
                root_reg[k] <= root_next[k];
                xs_reg[k]   <= xs_next[k];
            end
        end
    end

    assign out_vld = vld_reg[SQRT_STEPS];
    assign out_car = car_reg[SQRT_STEPS];
    assign out_d   = root_reg[SQRT_STEPS];

endmodule

### hdl/bpc_div.sv
module bpc_div
    import bpc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        adv,
    input  logic        in_vld,
    input  carry_t      in_car,
    input  logic [32:0] in_d,
    output logic        out_vld,
    output carry_t      out_car,
    output logic [32:0] out_d,
    output logic [30:0] out_qx,
    output logic [30:0] out_qy,
    output logic [30:0] out_qf
);

    logic        vld_reg [0:DIV_STEPS];
    carry_t      car_reg [0:DIV_STEPS];
    logic [32:0] d_reg   [0:DIV_STEPS];
    logic [32:0] rem_reg [0:DIV_STEPS][0:DIV_LANES-1];
    logic [30:0] lo_reg  [0:DIV_STEPS][0:DIV_LANES-1];

    logic [32:0] rem_next [1:DIV_STEPS][0:DIV_LANES-1];
    logic [30:0] lo_next  [1:DIV_STEPS][0:DIV_LANES-1];
    logic [62:0] num      [0:DIV_LANES-1];

    // Build rounded numerators
    always_comb
    begin
        logic [32:0] magx;
        logic [32:0] magy;
        magx = in_car.dx[32] ? 33'(-in_car.dx) : 33'(in_car.dx);
        magy = in_car.dy[32] ? 33'(-in_car.dy) : 33'(in_car.dy);
        num[LANE_X] = (63'(magx) << 30) + 63'(in_d >> 1);
        num[LANE_Y] = (63'(magy) << 30) + 63'(in_d >> 1);
        num[LANE_F] = (63'(in_car.p.b_mass) << 30) + 63'(in_car.msum >> 1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= DIV_STEPS; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else if (adv)
        begin
            vld_reg[0] <= in_vld;
            for (int k = 1; k <= DIV_STEPS; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    // One quotient bit per stage and lane
    always_comb
    begin
        logic [33:0] r2;
        logic [33:0] den;
        for (int k = 1; k <= DIV_STEPS; k++)
        begin
            for (int l = 0; l < DIV_LANES; l++)
            begin
                den = (l == LANE_F) ? {2'b00, car_reg[k-1].msum} : {1'b0, d_reg[k-1]};
                r2  = {rem_reg[k-1][l], lo_reg[k-1][l][30]};
                if (r2 >= den)
                begin
                    rem_next[k][l] = 33'(r2 - den);
                    lo_next[k][l]  = {lo_reg[k-1][l][29:0], 1'b1};
                end
                else
                begin
                    rem_next[k][l] = r2[32:0];
                    lo_next[k][l]  = {lo_reg[k-1][l][29:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            car_reg[0] <= in_car;
            d_reg[0]   <= in_d;
            for (int l = 0; l < DIV_LANES; l++)
            begin
                rem_reg[0][l] <= {1'b0, num[l][62:31]};
                lo_reg[0][l]  <= num[l][30:0];
            end
            for (int k = 1; k <= DIV_STEPS; k++)
            begin
                car_reg[k] <= car_reg[k-1];
                d_reg[k]   <= d_reg[k-1];
                for (int l = 0; l < DIV_LANES; l++)
                begin
                    rem_reg[k][l] <= rem_next[k][l];
                    lo_reg[k][l]  <= lo_next[k][l];
                end
            end
        end
    end

    assign out_vld = vld_reg[DIV_STEPS];
    assign out_car = car_reg[DIV_STEPS];
    assign out_d   = d_reg[DIV_STEPS];
    assign out_qx  = lo_reg[DIV_STEPS][LANE_X];
    assign out_qy  = lo_reg[DIV_STEPS][LANE_Y];
    assign out_qf  = lo_reg[DIV_STEPS][LANE_F];

endmodule

### hdl/bpc_resolve.sv
module bpc_resolve
    import bpc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        adv,
    input  logic        in_vld,
    input  carry_t      in_car,
    input  logic [32:0] in_d,
    input  logic [30:0] in_qx,
    input  logic [30:0] in_qy,
    input  logic [30:0] in_qf,
    input  logic [16:0] restitution,
    output logic        out_vld,
    output result_t     out_res
);

    logic        vld_reg [1:RES_STAGES];
    res_t        st_reg  [1:RES_STAGES];
    res_t        st_next [1:RES_STAGES];
    logic [17:0] ep;

    assign ep = REST_ONE + {1'b0, restitution};

    // Stage math, one slice of the formula per stage
    always_comb
    begin
        res_t               s;
        logic signed [40:0] w1;
        logic signed [40:0] w2;

        // Sign the normal, classify, overlap
        s    = '0;
        s.c  = in_car;
        s.d  = in_d;
        s.nx = in_car.dx[32] ? -$signed({1'b0, in_qx}) : $signed({1'b0, in_qx});
        s.ny = in_car.dy[32] ? -$signed({1'b0, in_qy}) : $signed({1'b0, in_qy});
        s.f2 = (in_car.msum == 32'd0) ? F_HALF : in_qf;
        s.ov = $signed({2'b00, in_car.rs}) - $signed({1'b0, in_d});
        if ({1'b0, in_car.rs} < in_d) s.cls = OUT_NONE;
        else if (in_d < NEAR_ZERO_RAW) s.cls = OUT_NUDGE;
        else s.cls = OUT_HIT;
        st_next[1] = s;

        for (int k = 2; k <= RES_STAGES; k++)
        begin
            s = st_reg[k-1];
            case (k)
                2:
                begin
                    s.pn1a = s.c.p.a_vx * s.nx;
                    s.pn1b = s.c.p.a_vy * s.ny;
                    s.pn2a = s.c.p.b_vx * s.nx;
                    s.pn2b = s.c.p.b_vy * s.ny;
                    s.pt1a = s.c.p.a_vy * s.nx;
                    s.pt1b = s.c.p.a_vx * s.ny;
                    s.pt2a = s.c.p.b_vy * s.nx;
                    s.pt2b = s.c.p.b_vx * s.ny;
                    s.pox  = s.ov * s.nx;
                    s.poy  = s.ov * s.ny;
                end
                3:
                begin
                    s.sn1 = s.pn1a + s.pn1b;
                    s.sn2 = s.pn2a + s.pn2b;
                    s.st1 = s.pt1a - s.pt1b;
                    s.st2 = s.pt2a - s.pt2b;
                end
                4:
                begin
                    s.v1n = 34'(rnd_sh(72'(s.sn1), 30));
                    s.v2n = 34'(rnd_sh(72'(s.sn2), 30));
                    s.v1t = 34'(rnd_sh(72'(s.st1), 30));
                    s.v2t = 34'(rnd_sh(72'(s.st2), 30));
                    s.px  = 34'(rnd_sh(72'(s.pox), 31));
                    s.py  = 34'(rnd_sh(72'(s.poy), 31));
                end
                5:
                begin
                    s.dv = s.v2n - s.v1n;
                    s.f1 = F_ONE - s.f2;
                end
                6:
                begin
                    s.pk1 = s.dv * $signed({1'b0, s.f2});
                    s.pk2 = s.dv * $signed({1'b0, s.f1});
                end
                7:
                begin
                    s.t1 = 37'(rnd_sh(72'(s.pk1), 30));
                    s.t2 = 37'(rnd_sh(72'(s.pk2), 30));
                end
                8:
                begin
                    s.pe1 = s.t1 * $signed({1'b0, ep});
                    s.pe2 = s.t2 * $signed({1'b0, ep});
                end
                9:
                begin
                    s.k1 = 40'(rnd_sh(72'(s.pe1), 16));
                    s.k2 = 40'(rnd_sh(72'(s.pe2), 16));
                end
                10:
                begin
                    // Exchange normal speeds and clamp
                    w1 = s.v1n + s.k1;
                    w2 = s.v2n - s.k2;
                    if (w1 > U_LIMIT) w1 = U_LIMIT;
                    else if (w1 < -U_LIMIT) w1 = -U_LIMIT;
                    if (w2 > U_LIMIT) w2 = U_LIMIT;
                    else if (w2 < -U_LIMIT) w2 = -U_LIMIT;
                    s.u1 = w1[34:0];
                    s.u2 = w2[34:0];
                end
                11:
                begin
                    s.qa1 = s.u1 * s.nx;
                    s.qb1 = s.u1 * s.ny;
                    s.qa2 = s.u2 * s.nx;
                    s.qb2 = s.u2 * s.ny;
                    s.qc1 = s.v1t * s.ny;
                    s.qd1 = s.v1t * s.nx;
                    s.qc2 = s.v2t * s.ny;
                    s.qd2 = s.v2t * s.nx;
                end
                12:
                begin
                    s.ra1 = 37'(rnd_sh(72'(s.qa1), 30));
                    s.rb1 = 37'(rnd_sh(72'(s.qb1), 30));
                    s.ra2 = 37'(rnd_sh(72'(s.qa2), 30));
                    s.rb2 = 37'(rnd_sh(72'(s.qb2), 30));
                    s.rc1 = 37'(rnd_sh(72'(s.qc1), 30));
                    s.rd1 = 37'(rnd_sh(72'(s.qd1), 30));
                    s.rc2 = 37'(rnd_sh(72'(s.qc2), 30));
                    s.rd2 = 37'(rnd_sh(72'(s.qd2), 30));
                end
                13:
                begin
                    // Select pass, nudge or resolved values
                    s.r.ax      = s.c.p.a_x;
                    s.r.ay      = s.c.p.a_y;
                    s.r.avx     = s.c.p.a_vx;
                    s.r.avy     = s.c.p.a_vy;
                    s.r.bx      = s.c.p.b_x;
                    s.r.by      = s.c.p.b_y;
                    s.r.bvx     = s.c.p.b_vx;
                    s.r.bvy     = s.c.p.b_vy;
                    s.r.outcome = s.cls;
                    case (s.cls)
                        OUT_NUDGE:
                        begin
                            s.r.ax = sat32(40'(s.c.p.a_x) + NUDGE_RAW);
                            s.r.ay = sat32(40'(s.c.p.a_y) + NUDGE_RAW);
                            s.r.bx = sat32(40'(s.c.p.b_x) - NUDGE_RAW);
                            s.r.by = sat32(40'(s.c.p.b_y) - NUDGE_RAW);
                        end
                        OUT_HIT:
                        begin
                            s.r.ax  = sat32(40'(s.c.p.a_x) + 40'(s.px));
                            s.r.ay  = sat32(40'(s.c.p.a_y) + 40'(s.py));
                            s.r.bx  = sat32(40'(s.c.p.b_x) - 40'(s.px));
                            s.r.by  = sat32(40'(s.c.p.b_y) - 40'(s.py));
                            s.r.avx = sat32(40'(s.ra1) - 40'(s.rc1));
                            s.r.avy = sat32(40'(s.rb1) + 40'(s.rd1));
                            s.r.bvx = sat32(40'(s.ra2) - 40'(s.rc2));
                            s.r.bvy = sat32(40'(s.rb2) + 40'(s.rd2));
                        end
                        default:
                        begin
                            s.r.outcome = OUT_NONE;
                        end
                    endcase
                end
                default:
                begin
                    s = st_reg[k-1];
                end
            endcase
            st_next[k] = s;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 1; k <= RES_STAGES; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else if (adv)
        begin
            vld_reg[1] <= in_vld;
            for (int k = 2; k <= RES_STAGES; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 1; k <= RES_STAGES; k++)
            begin
                st_reg[k] <= st_next[k];
            end
        end
    end

    assign out_vld = vld_reg[RES_STAGES];
    assign out_res = st_reg[RES_STAGES].r;

endmodule

### hdl/ball_pair_collision_resolve.sv
// Two-disc collision resolver, fully pipelined.
// Slave stream s_*: one disc pair per transaction in s_tdata.
// Master stream m_*: resolved pair in m_tdata, outcome code in m_tuser
// (0 no contact, 1 resolved, 2 coincident centers nudged).
// Config channel cfg_*: writes the restitution register (Q1.16); it is
// always ready and should only be written while no pair is in flight.
// Throughput: one pair per clock while m_tready does not stall the pipeline.
// The pipeline has 81 register stages: 3 distance stages, 33 square-root
// stages (one root bit each), 32 divider stages (a load stage, then one
// quotient bit each for both normal components and the mass fraction) and
// 13 arithmetic stages.
// The last arithmetic stage is the output register. When m_tready is low
// with a result waiting, the whole pipeline holds and s_tready drops; no
// transaction is lost or repeated.
// Reset clears all valid bits and loads restitution with 58982 (about 0.9).
module ball_pair_collision_resolve
    import bpc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // a_x, a_y, a_vx, a_vy, a_radius, a_mass, b_x, b_y, b_vx, b_vy,
    // b_radius, b_mass; zero pad to 384
    input  logic [383:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // new_a_x, new_a_y, new_a_vx, new_a_vy, new_b_x, new_b_y, new_b_vx, new_b_vy
    output logic [255:0] m_tdata,
    // outcome
    output logic [1:0]   m_tuser,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [16:0]  cfg_data
);

`include "assert_macros.svh"

    logic        adv;
    logic [16:0] restitution_reg;
    pair_t       in_pair;

    logic        dist_vld;
    carry_t      dist_car;
    logic [32:0] dist_d;

    logic        div_vld;
    carry_t      div_car;
    logic [32:0] div_d;
    logic [30:0] div_qx, div_qy, div_qf;

    result_t     res;

    // Move the pipeline unless a result waits on a stalled receiver
    assign adv       = !m_tvalid || m_tready;
    assign s_tready  = adv;
    assign cfg_ready = 1'b1;

    // Unpack the input transaction
    assign in_pair.a_x      = s_tdata[31:0];
    assign in_pair.a_y      = s_tdata[63:32];
    assign in_pair.a_vx     = s_tdata[95:64];
    assign in_pair.a_vy     = s_tdata[127:96];
    assign in_pair.a_radius = s_tdata[158:128];
    assign in_pair.a_mass   = s_tdata[189:159];
    assign in_pair.b_x      = s_tdata[221:190];
    assign in_pair.b_y      = s_tdata[253:222];
    assign in_pair.b_vx     = s_tdata[285:254];
    assign in_pair.b_vy     = s_tdata[317:286];
    assign in_pair.b_radius = s_tdata[348:318];
    assign in_pair.b_mass   = s_tdata[379:349];

    // Hold the restitution register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            restitution_reg <= REST_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            restitution_reg <= cfg_data;
        end
    end

    bpc_dist u_dist (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .in_vld  (s_tvalid),
        .in_pair (in_pair),
        .out_vld (dist_vld),
        .out_car (dist_car),
        .out_d   (dist_d)
    );

    bpc_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .in_vld  (dist_vld),
        .in_car  (dist_car),
        .in_d    (dist_d),
        .out_vld (div_vld),
        .out_car (div_car),
        .out_d   (div_d),
        .out_qx  (div_qx),
        .out_qy  (div_qy),
        .out_qf  (div_qf)
    );

    bpc_resolve u_resolve (
        .clk         (clk),
        .rst_n       (rst_n),
        .adv         (adv),
        .in_vld      (div_vld),
        .in_car      (div_car),
        .in_d        (div_d),
        .in_qx       (div_qx),
        .in_qy       (div_qy),
        .in_qf       (div_qf),
        .restitution (restitution_reg),
        .out_vld     (m_tvalid),
        .out_res     (res)
    );

    // Pack the result transaction
    assign m_tdata = {res.bvy, res.bvx, res.by, res.bx,
                      res.avy, res.avx, res.ay, res.ax};
    assign m_tuser = res.outcome;

    `BPC_ASSERT(a_outcome_code,
        m_tvalid |-> (m_tuser == OUT_NONE || m_tuser == OUT_HIT || m_tuser == OUT_NUDGE))
    `BPC_ASSERT_MSG(a_stall_keeps_result, !s_tready |=> m_tvalid,
        "stalled pipeline dropped its result")
    `BPC_ASSERT_MSG(a_cfg_write, cfg_valid |=> restitution_reg == $past(cfg_data),
        "restitution write not taken")

endmodule

### tb/sv/tb_top.sv
module tb_top;
    import bpc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [127:0] wide_t;

    // One expected resolved pair
    typedef struct {
        logic [31:0] word [8];
        logic [1:0]  outcome;
    } resolved_t;

    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_CYCLES = 200;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [383:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [255:0] m_tdata;
    logic [1:0]   m_tuser;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [16:0]  cfg_data;

    logic [16:0]  restitution_copy;
    resolved_t    pending_q[$];
    int           errors;
    int           pairs_sent;
    int           results_seen;
    int           outcome_count [3];
    int           cycles;
    int           stall_left;
    bit           no_idle;

    string word_names [8] = '{"new_a_x", "new_a_y", "new_a_vx", "new_a_vy",
                              "new_b_x", "new_b_y", "new_b_vx", "new_b_vy"};

    ball_pair_collision_resolve dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    // Generate the clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Count cycles and stop a hung run
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("timeout after %0d cycles", cycles);
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    // Round half away from zero, then shift right by s
    function automatic wide_t round_shift(input wide_t p, input int s);
        logic [127:0] m;
        bit neg;
        neg = p < 0;
        m = neg ? -p : p;
        m = (m + (128'd1 << (s - 1))) >> s;
        return neg ? -wide_t'(m) : wide_t'(m);
    endfunction

    function automatic wide_t clip32(input wide_t v);
        if (v > 128'sd2147483647) return 128'sd2147483647;
        if (v < -128'sd2147483648) return -128'sd2147483648;
        return v;
    endfunction

    function automatic wide_t clip_speed(input wide_t v);
        if (v > 128'sd8589934591) return 128'sd8589934591;
        if (v < -128'sd8589934591) return -128'sd8589934591;
        return v;
    endfunction

    // Floor of the square root, one result bit per step
    function automatic wide_t floor_sqrt(input wide_t x);
        wide_t r;
        wide_t t;
        r = 0;
        for (int i = 34; i >= 0; i--)
        begin
            t = r | (wide_t'(1) << i);
            if (t * t <= x) r = t;
        end
        return r;
    endfunction

    // Unit normal component in Q2.30
    function automatic wide_t unit_comp(input wide_t c, input wide_t d);
        wide_t m;
        m = (((c < 0) ? -c : c) << 30) + d / 2;
        m = m / d;
        return (c < 0) ? -m : m;
    endfunction

    // Work out the resolved pair for one input pair
    function automatic resolved_t resolve_pair(input pair_t p);
        resolved_t res;
        wide_t ax, ay, avx, avy, ar, am, bx, by, bvx, bvy, br, bm;
        wide_t dx, dy, d, rs, nx, ny, ov, px, py;
        wide_t v1n, v2n, v1t, v2t, msum, f1, f2, ep, dv, k1, k2, u1, u2;
        wide_t w [8];
        ax = p.a_x;  ay = p.a_y;  avx = p.a_vx; avy = p.a_vy;
        bx = p.b_x;  by = p.b_y;  bvx = p.b_vx; bvy = p.b_vy;
        ar = {97'd0, p.a_radius}; am = {97'd0, p.a_mass};
        br = {97'd0, p.b_radius}; bm = {97'd0, p.b_mass};
        dx = ax - bx;
        dy = ay - by;
        d = floor_sqrt(dx * dx + dy * dy);
        rs = ar + br;
        w = '{ax, ay, avx, avy, bx, by, bvx, bvy};
        if (rs < d)
        begin
            res.outcome = OUT_NONE;
        end
        else if (d < 7)
        begin
            w[0] = clip32(ax + 6554);
            w[1] = clip32(ay + 6554);
            w[4] = clip32(bx - 6554);
            w[5] = clip32(by - 6554);
            res.outcome = OUT_NUDGE;
        end
        else
        begin
            nx = unit_comp(dx, d);
            ny = unit_comp(dy, d);
            ov = rs - d;
            px = round_shift(ov * nx, 31);
            py = round_shift(ov * ny, 31);
            v1n = round_shift(avx * nx + avy * ny, 30);
            v2n = round_shift(bvx * nx + bvy * ny, 30);
            v1t = round_shift(avy * nx - avx * ny, 30);
            v2t = round_shift(bvy * nx - bvx * ny, 30);
            msum = am + bm;
            f2 = (msum == 0) ? (wide_t'(1) << 29) : ((bm << 30) + msum / 2) / msum;
            f1 = (wide_t'(1) << 30) - f2;
            ep = 65536 + wide_t'({111'd0, restitution_copy});
            dv = v2n - v1n;
            k1 = round_shift(round_shift(dv * f2, 30) * ep, 16);
            k2 = round_shift(round_shift(dv * f1, 30) * ep, 16);
            u1 = clip_speed(v1n + k1);
            u2 = clip_speed(v2n - k2);
            w[0] = clip32(ax + px);
            w[1] = clip32(ay + py);
            w[4] = clip32(bx - px);
            w[5] = clip32(by - py);
            w[2] = clip32(round_shift(u1 * nx, 30) + round_shift(-(v1t * ny), 30));
            w[3] = clip32(round_shift(u1 * ny, 30) + round_shift(v1t * nx, 30));
            w[6] = clip32(round_shift(u2 * nx, 30) + round_shift(-(v2t * ny), 30));
            w[7] = clip32(round_shift(u2 * ny, 30) + round_shift(v2t * nx, 30));
            res.outcome = OUT_HIT;
        end
        for (int i = 0; i < 8; i++) res.word[i] = w[i][31:0];
        return res;
    endfunction

    // Pack a pair, first field in the lowest bits
    function automatic logic [383:0] pack_pair(input pair_t p);
        return {4'd0, p.b_mass, p.b_radius, p.b_vy, p.b_vx, p.b_y, p.b_x,
                p.a_mass, p.a_radius, p.a_vy, p.a_vx, p.a_y, p.a_x};
    endfunction

    function automatic pair_t mk_pair(
        input logic [31:0] ax, input logic [31:0] ay, input logic [31:0] avx,
        input logic [31:0] avy, input logic [30:0] ar, input logic [30:0] am,
        input logic [31:0] bx, input logic [31:0] by, input logic [31:0] bvx,
        input logic [31:0] bvy, input logic [30:0] br, input logic [30:0] bm);
        pair_t p;
        p.a_x = ax; p.a_y = ay; p.a_vx = avx; p.a_vy = avy;
        p.a_radius = ar; p.a_mass = am;
        p.b_x = bx; p.b_y = by; p.b_vx = bvx; p.b_vy = bvy;
        p.b_radius = br; p.b_mass = bm;
        return p;
    endfunction

    // Gap length: mostly none or short, now and then long
    function automatic int gap_len();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Send one pair and record its expected result on acceptance
    task automatic send_pair(input pair_t p);
        int gap;
        s_tdata <= pack_pair(p);
        s_tvalid <= 1'b1;
        do @(posedge clk); while (!s_tready);
        pending_q = {pending_q, resolve_pair(p)};
        pairs_sent++;
        @(negedge clk);
        gap = gap_len();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    // Let every outstanding pair come back
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_q.size() != 0) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_restitution(input logic [16:0] value);
        drain();
        cfg_data <= value;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        restitution_copy = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Draw a pair, mostly close enough to collide
    function automatic pair_t rand_pair();
        pair_t p;
        int mode;
        logic [31:0] sc;
        mode = $urandom_range(0, 99);
        p = mk_pair($urandom, $urandom, $urandom, $urandom, 31'($urandom), 31'($urandom),
                    $urandom, $urandom, $urandom, $urandom, 31'($urandom), 31'($urandom));
        if (p.a_mass == 0) p.a_mass = 1;
        if (p.b_mass == 0) p.b_mass = 1;
        if (mode < 65)
        begin
            // Overlapping discs with moderate speeds
            sc = 32'd1 << $urandom_range(8, 26);
            p.a_radius = 31'($urandom_range(0, sc));
            p.b_radius = 31'($urandom_range(0, sc));
            p.b_x = p.a_x + $signed($urandom_range(0, 2 * sc)) - $signed(sc);
            p.b_y = p.a_y + $signed($urandom_range(0, 2 * sc)) - $signed(sc);
            p.a_vx = $signed(p.a_vx) >>> $urandom_range(0, 16);
            p.a_vy = $signed(p.a_vy) >>> $urandom_range(0, 16);
            p.b_vx = $signed(p.b_vx) >>> $urandom_range(0, 16);
            p.b_vy = $signed(p.b_vy) >>> $urandom_range(0, 16);
            p.a_mass = p.a_mass >> $urandom_range(0, 24);
            p.b_mass = p.b_mass >> $urandom_range(0, 24);
            if (p.a_mass == 0) p.a_mass = 1;
            if (p.b_mass == 0) p.b_mass = 1;
        end
        else if (mode < 80)
        begin
            // Nearly coincident centers, around the near-zero threshold
            p.b_x = p.a_x + $signed($urandom_range(0, 10)) - 5;
            p.b_y = p.a_y + $signed($urandom_range(0, 10)) - 5;
            p.a_radius = 31'($urandom_range(0, 8));
        end
        return p;
    endfunction

    task automatic test_directed();
        pair_t list [$];
        list = {list, mk_pair(0, 0, 0, 0, 10 << 16, 1 << 16,
                              100 << 16, 0, 0, 0, 10 << 16, 1 << 16)};
        list = {list, mk_pair(0, 0, 1 << 16, 0, 10 << 16, 1 << 16,
                              20 << 16, 0, -(1 << 16), 0, 10 << 16, 1 << 16)};
        list = {list, mk_pair(0, 0, 0, 0, 10 << 16, 1 << 16,
                              (20 << 16) + 1, 0, 0, 0, 10 << 16, 1 << 16)};
        list = {list, mk_pair(5, 5, 3, 4, 1, 1, 5, 5, 7, 8, 1, 1)};
        list = {list, mk_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0)};
        list = {list, mk_pair(6, 0, 1, 2, 3, 5, 0, 0, 3, 4, 3, 5)};
        list = {list, mk_pair(7, 0, 1 << 16, 2, 4, 5, 0, 0, 3, 4, 3, 7)};
        list = {list, mk_pair(32'h7FFFFFFF, 32'h7FFFFFFF, 0, 0, 1, 1,
                              32'h7FFFFFFF, 32'h7FFFFFFF, 0, 0, 1, 1)};
        list = {list, mk_pair(32'h80000000, 32'h80000000, 0, 0, 1, 1,
                              32'h80000000, 32'h80000000, 0, 0, 1, 1)};
        list = {list, mk_pair(32'h7FFFFFFF, 0, 0, 0, 31'h7FFFFFFF, 1,
                              32'h80000000, 0, 0, 0, 31'h7FFFFFFF, 1)};
        list = {list, mk_pair(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000,
                              31'h7FFFFFFF, 31'h7FFFFFFF, 0, 0, 32'h80000000,
                              32'h7FFFFFFF, 31'h7FFFFFFF, 1)};
        list = {list, mk_pair(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                              31'h7FFFFFFF, 1, 32'h7FFFFFFF, 32'h7FFFFFFF,
                              32'h7FFFFFFF, 32'h7FFFFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF)};
        list = {list, mk_pair(0, 0, 1 << 16, 1 << 16, 5 << 16, 1,
                              3 << 16, 4 << 16, 0, -(2 << 16), 5 << 16, 31'h7FFFFFFF)};
        list = {list, mk_pair(100 << 16, -(50 << 16), -(3 << 16), 7 << 16, 6 << 16,
                              2 << 16, 95 << 16, -(47 << 16), 2 << 16, -(1 << 16),
                              4 << 16, 3 << 16)};
        list = {list, mk_pair(-(9 << 16), 12 << 16, 32'h0000FFFF, 32'hFFFF0001, 31'd1,
                              31'h7FFFFFFF, -(9 << 16), (12 << 16) + 9, 32'h7FFFFFFF,
                              32'h80000000, 31'd8, 31'h7FFFFFFF)};
        foreach (list[i]) send_pair(list[i]);
        drain();
    endtask

    task automatic test_random(input logic [16:0] value, input int count);
        write_restitution(value);
        repeat (count) send_pair(rand_pair());
        drain();
    endtask

    // Drive the sink's ready with random stalls
    initial
    begin
        m_tready = 1'b0;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else
            begin
                m_tready <= 1'b1;
                if (!no_idle && $urandom_range(0, 99) < 25)
                    stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                             : $urandom_range(1, 3);
            end
        end
    end

    // Compare each result transaction with the oldest expectation
    initial
    begin
        resolved_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                results_seen++;
                if (pending_q.size() == 0)
                begin
                    $error("result with no pair outstanding");
                    errors++;
                end
                else
                begin
                    want = pending_q.pop_front();
                    for (int i = 0; i < 8; i++)
                        if (m_tdata[32 * i +: 32] !== want.word[i])
                        begin
                            $error("%s: expected %0d, got %0d", word_names[i],
                                   $signed(want.word[i]), $signed(m_tdata[32 * i +: 32]));
                            errors++;
                        end
                    if (m_tuser !== want.outcome)
                    begin
                        $error("outcome: expected %0d, got %0d", want.outcome, m_tuser);
                        errors++;
                    end
                    if (want.outcome <= 2) outcome_count[want.outcome]++;
                end
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        no_idle = 1'b0;
        errors = 0;
        pairs_sent = 0;
        results_seen = 0;
        outcome_count = '{0, 0, 0};
        restitution_copy = REST_RESET;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_random(17'd0, 300);
        test_random(17'd65536, 300);
        test_random(17'h1FFFF, 300);
        no_idle = 1'b1;
        test_random(17'd32768, 300);
        no_idle = 1'b0;
        test_random(17'($urandom), 300);
        test_random(REST_RESET, 300);

        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("sent %0d pairs under 6 restitution values, %0d results checked",
                 pairs_sent, results_seen);
        $display("outcomes: %0d no contact, %0d resolved, %0d nudged",
                 outcome_count[0], outcome_count[1], outcome_count[2]);
        if (errors == 0 && pending_q.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
